/* design/hbs_pkg.sv */
// Shared types, constants and register map of the histogram box smoothing unit.
package hbs_pkg;

    localparam int MAX_BINS_X_DEF = 64;
    localparam int MAX_BINS_Y_DEF = 64;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int COORD_W = 6;
    localparam int COUNT_W = 7;
    localparam int RAD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 40;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_BINS_X = 2'd0;
    localparam logic [1:0] REG_BINS_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] bins_x;
        logic [COUNT_W-1:0] bins_y;
        logic [RAD_W-1:0]   radius;
    } t_cfg;

endpackage

/* design/hbs_regs.sv */
// APB configuration registers: bin counts and window radius.
module hbs_regs
    import hbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bins_x <= COUNT_W'(64);
            r_cfg.bins_y <= COUNT_W'(64);
            r_cfg.radius <= RAD_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BINS_X: r_cfg.bins_x <= pwdata[COUNT_W-1:0];
                REG_BINS_Y: r_cfg.bins_y <= pwdata[COUNT_W-1:0];
                REG_RADIUS: r_cfg.radius <= pwdata[RAD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BINS_X: prdata = PDATA_W'(r_cfg.bins_x);
            REG_BINS_Y: prdata = PDATA_W'(r_cfg.bins_y);
            REG_RADIUS: prdata = PDATA_W'(r_cfg.radius);
            default:    prdata = '0;
        endcase
    end

endmodule

/* design/hbs_mem.sv */
// Grid memory: one write port, one read port with registered read data.
module hbs_mem
    import hbs_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] mem [(1 << AW)];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/hbs_ctrl.sv */
// Sequencer: load writes, window bounds, grid scan and accumulation, result register.
module hbs_ctrl
    import hbs_pkg::*;
#(
    parameter int MAX_BINS_X = MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = MAX_BINS_Y_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    localparam int XW = $clog2(MAX_BINS_X),
    localparam int YW = $clog2(MAX_BINS_Y),
    localparam int AW = XW + YW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [COORD_W-1:0] i_bin_x,
    input  logic [COORD_W-1:0] i_bin_y,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SUM_W-1:0]   o_window_sum,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [VAL_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [VAL_W-1:0]   i_mem_rdata
);

    // working widths: hold a count, a coordinate plus radius, and the 7-bit registers
    localparam int XCW = ((XW + 2) > 8) ? (XW + 2) : 8;
    localparam int YCW = ((YW + 2) > 8) ? (YW + 2) : 8;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BOUND = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [COORD_W-1:0]   r_cx, r_cy;
    logic [XW-1:0]        r_x, n_x, r_xhi, n_xhi;
    logic [YW-1:0]        r_y, n_y, r_ylo, n_ylo, r_yhi, n_yhi;
    logic                 r_rd_v, n_rd_v;
    logic [SUM_W-1:0]     r_acc;
    logic                 r_out_valid, n_out_valid;
    logic [SUM_W-1:0]     r_out_sum;
    logic                 out_load;

    logic                 in_acc;
    logic [XCW-1:0]       bx_ext, cx_ext, nx, rx, xlo, xhi_raw, xhi;
    logic [YCW-1:0]       by_ext, cy_ext, ny, ry, ylo, yhi_raw, yhi;
    logic                 win_empty;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // load path: written at the accepting edge
    assign bx_ext      = XCW'(i_bin_x);
    assign by_ext      = YCW'(i_bin_y);
    assign o_mem_we    = in_acc && (i_kind == KIND_LOAD)
                         && (bx_ext < XCW'(MAX_BINS_X)) && (by_ext < YCW'(MAX_BINS_Y));
    assign o_mem_waddr = {bx_ext[XW-1:0], by_ext[YW-1:0]};
    assign o_mem_wdata = i_value;
    assign o_mem_raddr = {r_x, r_y};

    // clipped window bounds
    always_comb begin
        cx_ext = XCW'(r_cx);
        cy_ext = YCW'(r_cy);
        if (i_cfg.bins_x == '0)
            nx = XCW'(1);
        else if (XCW'(i_cfg.bins_x) > XCW'(MAX_BINS_X))
            nx = XCW'(MAX_BINS_X);
        else
            nx = XCW'(i_cfg.bins_x);
        if (i_cfg.bins_y == '0)
            ny = YCW'(1);
        else if (YCW'(i_cfg.bins_y) > YCW'(MAX_BINS_Y))
            ny = YCW'(MAX_BINS_Y);
        else
            ny = YCW'(i_cfg.bins_y);
        rx = (XCW'(i_cfg.radius) > XCW'(MAX_RADIUS)) ? XCW'(MAX_RADIUS)
                                                     : XCW'(i_cfg.radius);
        ry = (YCW'(i_cfg.radius) > YCW'(MAX_RADIUS)) ? YCW'(MAX_RADIUS)
                                                     : YCW'(i_cfg.radius);
        xlo     = (cx_ext > rx) ? (cx_ext - rx) : '0;
        ylo     = (cy_ext > ry) ? (cy_ext - ry) : '0;
        xhi_raw = cx_ext + rx;
        yhi_raw = cy_ext + ry;
        xhi     = (xhi_raw > nx - XCW'(1)) ? (nx - XCW'(1)) : xhi_raw;
        yhi     = (yhi_raw > ny - YCW'(1)) ? (ny - YCW'(1)) : yhi_raw;
        win_empty = (xlo > xhi) || (ylo > yhi);
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_xhi   = r_xhi;
        n_ylo   = r_ylo;
        n_yhi   = r_yhi;
        n_rd_v  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_kind == KIND_QUERY))
                    n_state = S_BOUND;
            end
            S_BOUND: begin
                n_x   = xlo[XW-1:0];
                n_y   = ylo[YW-1:0];
                n_xhi = xhi[XW-1:0];
                n_ylo = ylo[YW-1:0];
                n_yhi = yhi[YW-1:0];
                n_state = win_empty ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                n_rd_v = 1'b1;
                if (r_y == r_yhi) begin
                    n_y = r_ylo;
                    if (r_x == r_xhi)
                        n_state = S_WAIT;
                    else
                        n_x = r_x + XW'(1);
                end else begin
                    n_y = r_y + YW'(1);
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load)
            n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_xhi <= n_xhi;
        r_ylo <= n_ylo;
        r_yhi <= n_yhi;
        if (in_acc) begin
            r_cx <= i_bin_x;
            r_cy <= i_bin_y;
        end
        // read data arrives in the cycle after its address, marked by r_rd_v
        if (in_acc)
            r_acc <= '0;
        else if (r_rd_v)
            r_acc <= r_acc + {{(SUM_W-VAL_W){i_mem_rdata[VAL_W-1]}}, i_mem_rdata};
        if (out_load)
            r_out_sum <= r_acc;
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_sum = r_out_sum;

`ifndef SYNTH
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_x <= r_xhi) && (r_y <= r_yhi) && (r_y >= r_ylo))
        else $error("scan address outside window");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_IDLE))
        else $error("grid written while a query runs");
    a_rd_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> r_rd_v)
        else $error("scan read not accumulated");
    a_wait_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |=> (r_state == S_DONE) && !r_rd_v)
        else $error("last read beat not closed");
`endif

endmodule

/* design/histogram_box_smoothing_unit.sv */
// Top level of the histogram box smoothing unit.
// A load beat whose bin lies inside the grid writes that bin of the grid memory at the accepting edge.
// A query beat sums the bins of the square window of the configured radius around the
// addressed bin, clipped to the bins in use; the grid memory has one read port, so, after
// a bounds state, the scan reads one bin a cycle over a clipped window of wx by wy bins
// (up to 15 each at radius 7); the sequencer then steps through its wait and done states
// and registers the sum. A window clipped to nothing skips the scan and returns zero. The
// result waits in an output register, and a new beat is taken once the query has handed
// its sum to that register.
module histogram_box_smoothing_unit
    import hbs_pkg::*;
#(
    parameter int MAX_BINS_X = MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = MAX_BINS_Y_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [COORD_W-1:0] i_bin_x,
    input  logic [COORD_W-1:0] i_bin_y,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SUM_W-1:0]   o_window_sum
);

    localparam int AW = $clog2(MAX_BINS_X) + $clog2(MAX_BINS_Y);

    t_cfg             cfg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    hbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hbs_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hbs_ctrl #(
        .MAX_BINS_X (MAX_BINS_X),
        .MAX_BINS_Y (MAX_BINS_Y),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_bin_x      (i_bin_x),
        .i_bin_y      (i_bin_y),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_sum (o_window_sum),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

endmodule
